// ----- rtl/lph_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lph_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int LIMIT_W = 10;
    localparam logic [31:0] HASH_MULT = 32'h045d9f3b;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FIND   = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture request and start hashing
        logic mix_step;  // advance hash by one stage
        logic set_home;  // load probe pointer from hash
        logic rd_slot;   // issue memory read at probe pointer
        logic advance;   // step probe pointer
        logic wr_new;    // write key, value and valid
        logic wr_val;    // overwrite value only
        logic take_val;  // capture read value for a hit
        logic clr_step;  // clear one valid entry in sweep
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_valid;
        logic key_match;
        logic walk_done;   // all slots visited
        logic room;        // live count below limit
        logic is_find;
        logic clr_done;
    } t_stat;

endpackage
`default_nettype wire

// ----- rtl/linear_probe_hash_table.sv -----
// Channel   Dir  Bits  Contents
// s_axis    in   72    tdata: func[0], key[32:1], value[64:33], zero pad
// m_axis    out  40    tdata: found[0], value_out[32:1], status[33], zero pad
// apb       in   -     fill_limit at byte address 0
// Each request runs the hash steps and setup, then a read and a check for each slot probed,
// then the output state; the probe loop goes through the single-port slot memory one slot at a time.
// After reset a sweep clears all TABLE_SLOTS valid bits; no request is
// taken during it. A result waits in the output register until taken.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,   // func, key, value
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // found, value_out, status
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lph_pkg::*;

    lph_pkg::t_cmd  w_cmd;
    lph_pkg::t_stat w_stat;
    logic [9:0]  r_fill_limit;
    logic        w_found, w_status;
    logic [31:0] w_vout;

    assign pready = 1'b1;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fill_limit <= 10'd819;
        else if (psel && penable && pwrite && paddr == 2'd0)
            r_fill_limit <= pwdata[9:0];
    end
    assign prdata = (paddr == 2'd0) ? {22'd0, r_fill_limit} : 32'd0;

    lph_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_found(w_found), .o_status(w_status),
        .o_cmd(w_cmd), .i_stat(w_stat)
    );

    lph_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .i_func(s_axis_tdata[0]), .i_key(s_axis_tdata[32:1]),
        .i_value(s_axis_tdata[64:33]), .i_fill_limit(r_fill_limit),
        .o_value_out(w_vout)
    );

    assign m_axis_tdata = {6'd0, w_status, w_vout, w_found};

endmodule
`default_nettype wire

// ----- rtl/lph_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lph_datapath #(
    parameter int TABLE_SLOTS = 1024
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire  lph_pkg::t_cmd       i_cmd,
    output lph_pkg::t_stat            o_stat,
    input  wire                       i_func,
    input  wire  [31:0]               i_key,
    input  wire  [31:0]               i_value,
    input  wire  [9:0]                i_fill_limit,
    output logic [31:0]               o_value_out
);
    import lph_pkg::*;

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = AW + 1;

    logic [KEY_W-1:0] r_keys [TABLE_SLOTS];
    logic [VAL_W-1:0] r_vals [TABLE_SLOTS];
    logic             r_valid [TABLE_SLOTS];

    logic [31:0]   r_key, r_value, r_hash;
    logic          r_func;
    logic [1:0]    r_mix;
    logic [AW-1:0] r_ptr;
    logic [CW-1:0] r_visits;
    logic [10:0]   r_live;
    logic [31:0]   r_rd_key, r_rd_val;
    logic          r_rd_valid;
    logic [AW-1:0] r_clr;
    logic          r_clr_done;
    logic [31:0]   r_vout;
    logic [31:0]   w_x;

    // One hash stage per cycle: xor-shift then multiply, but the last stage is xor-shift only.
    assign w_x = r_hash ^ (r_hash >> 16);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key;
            r_value <= i_value;
            r_func  <= i_func;
            r_hash  <= i_key;
            r_mix   <= 2'd0;
        end else if (i_cmd.mix_step) begin
            r_hash <= (r_mix == 2'd2) ? w_x : w_x * HASH_MULT;
            r_mix  <= r_mix + 2'd1;
        end
    end

    // Probe pointer and visit count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_home) begin
            r_ptr    <= r_hash[AW-1:0];
            r_visits <= '0;
        end else if (i_cmd.advance) begin
            r_ptr    <= r_ptr + AW'(1);
            r_visits <= r_visits + CW'(1);
        end
    end

    // Slot memories, registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) r_keys[r_ptr] <= r_key;
        if (i_cmd.wr_new || i_cmd.wr_val) r_vals[r_ptr] <= r_value;
        if (i_cmd.rd_slot) begin
            r_rd_key <= r_keys[r_ptr];
            r_rd_val <= r_vals[r_ptr];
        end
    end

    // Valid bits are a memory too, cleared by a sweep after reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) r_valid[r_clr] <= 1'b0;
        else if (i_cmd.wr_new) r_valid[r_ptr] <= 1'b1;
        if (i_cmd.rd_slot) r_rd_valid <= r_valid[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_live     <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
                if (r_clr == AW'(TABLE_SLOTS - 1)) r_clr_done <= 1'b1;
            end
            if (i_cmd.wr_new) r_live <= r_live + 11'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_vout <= '0;
        else if (i_cmd.take_val) r_vout <= r_rd_val;
    end

    assign o_value_out       = r_vout;
    assign o_stat.slot_valid = r_rd_valid;
    assign o_stat.key_match  = (r_rd_key == r_key);
    assign o_stat.walk_done  = (r_visits == CW'(TABLE_SLOTS));
    assign o_stat.room       = ({1'b0, r_live} + 12'd1) <= {2'b0, i_fill_limit};
    assign o_stat.is_find    = (r_func == FUNC_FIND);
    assign o_stat.clr_done   = r_clr_done;

endmodule
`default_nettype wire

// ----- rtl/lph_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lph_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_found,
    output logic                o_status,
    output lph_pkg::t_cmd       o_cmd,
    input  wire  lph_pkg::t_stat i_stat
);
    import lph_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_found, n_found, r_status, n_status;
    logic       w_accept;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_found     = r_found;
    assign o_status    = r_status;

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_found  = r_found;
        n_status = r_status;
        o_cmd    = '0;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) n_state = S_IDLE;
                else o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_found    = 1'b0;
                    n_status   = STATUS_DONE;
                    n_cnt      = 2'd0;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                if (r_cnt == 2'd3) begin
                    o_cmd.set_home = 1'b1;
                    n_state = S_READ;
                end else begin
                    o_cmd.mix_step = 1'b1;
                    n_cnt = r_cnt + 2'd1;
                end
            end
            S_READ: begin
                if (i_stat.walk_done) begin
                    n_status = i_stat.is_find ? STATUS_DONE : STATUS_FULL;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.rd_slot = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_OUT;
                if (!i_stat.slot_valid) begin
                    if (!i_stat.is_find) begin
                        if (i_stat.room) o_cmd.wr_new = 1'b1;
                        else n_status = STATUS_FULL;
                    end
                end else if (i_stat.key_match) begin
                    n_found = 1'b1;
                    if (i_stat.is_find) o_cmd.take_val = 1'b1;
                    else o_cmd.wr_val = 1'b1;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_READ;
                end
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_found  <= 1'b0;
            r_status <= STATUS_DONE;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lph_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lph_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata
);
    // No new request is taken while a result is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
    // A refused insert never reports a hit.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[33]) |-> !m_axis_tdata[0])
        else $error("full with found");
    // A miss returns zero value.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tdata[32:1] == 32'd0)
        else $error("nonzero value on miss");
    // Accepted request yields no result next cycle (hashing runs).
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result too early");
endmodule

bind linear_probe_hash_table lph_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ----- tb/sv/tb_linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
module tb_linear_probe_hash_table;
    import lph_pkg::*;

    localparam int SLOTS = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_N = 512;
    localparam int RAND_ITEMS = 1680;
    localparam logic [1:0] REG_FILL_LIMIT = 2'd0;

    typedef struct {
        bit          cfg;
        bit [9:0]    limit;
        bit          func;
        bit [31:0]   key;
        bit [31:0]   val;
        bit          typed;
        bit          ef;
        bit [31:0]   ev;
        bit          es;
    } t_plan_row;

    typedef struct {
        bit          found;
        bit [31:0]   value_out;
        bit          status;
    } t_lookup_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    wire         s_axis_tready;
    logic [71:0] s_axis_tdata;   // func[0], key[32:1], value[64:33], zero pad
    wire         m_axis_tvalid;
    logic        m_axis_tready;
    wire  [39:0] m_axis_tdata;   // found[0], value_out[32:1], status[33], zero pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    linear_probe_hash_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the table used to predict each response.
    bit [31:0]   shadow_keys [SLOTS];
    bit [31:0]   shadow_vals [SLOTS];
    bit          shadow_valid [SLOTS];
    int unsigned shadow_live;
    bit [9:0]    shadow_limit;

    t_lookup_res pending_results[$];
    bit [31:0]   key_pool [POOL_N];
    t_plan_row   plan [20];
    int          mismatches;
    int          cycles;
    bit          idle_on;
    int          hold_cycles;

    function automatic bit [31:0] mix_hash(bit [31:0] x);
        x = ((x >> 16) ^ x) * HASH_MULT;
        x = ((x >> 16) ^ x) * HASH_MULT;
        return (x >> 16) ^ x;
    endfunction

    // Walk the shadow table like the hardware and apply the request.
    function automatic t_lookup_res apply_request(bit func, bit [31:0] key, bit [31:0] val);
        t_lookup_res r;
        int          pos;
        int          hit;
        int          where;
        r = '{1'b0, 32'd0, STATUS_DONE};
        pos = int'(mix_hash(key) % SLOTS);
        hit = -1;
        where = 0;
        for (int n = 0; n < SLOTS; n++) begin
            if (!shadow_valid[pos]) begin
                hit = 0;
                where = pos;
                break;
            end
            if (shadow_keys[pos] == key) begin
                hit = 1;
                where = pos;
                break;
            end
            pos = (pos + 1) % SLOTS;
        end
        if (func == FUNC_FIND) begin
            if (hit == 1) begin
                r.found = 1'b1;
                r.value_out = shadow_vals[where];
            end
        end else if (hit == 1) begin
            shadow_vals[where] = val;
            r.found = 1'b1;
        end else if (hit == 0 && shadow_live + 1 <= shadow_limit) begin
            shadow_keys[where] = key;
            shadow_vals[where] = val;
            shadow_valid[where] = 1'b1;
            shadow_live++;
        end else begin
            r.status = STATUS_FULL;
        end
        return r;
    endfunction

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle counter with a hard timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random back pressure plus an occasional long hold-off.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= idle_on ? ($urandom_range(99) >= 23) : 1'b1;
        end
    end

    // Compare each response against the oldest pending prediction.
    always @(posedge i_clk) begin
        t_lookup_res exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", m_axis_tdata);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[0] !== exp_r.found || m_axis_tdata[32:1] !== exp_r.value_out
                        || m_axis_tdata[33] !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp found=%0d value=%h status=%0d, got %0d %h %0d",
                                 exp_r.found, exp_r.value_out, exp_r.status,
                                 m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[33]);
                end
            end
        end
    end

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Stop offering requests, let the block empty, then write the register.
    task automatic write_fill_limit(bit [9:0] limit);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        drain_results();
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = REG_FILL_LIMIT;
        pwdata = {22'd0, limit};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_limit = limit;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Offer one request and record its prediction when it is accepted.
    task automatic send_request(bit func, bit [31:0] key, bit [31:0] val,
                                bit typed, t_lookup_res typed_res);
        t_lookup_res r;
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 23) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {7'd0, val, key, func};
        do @(posedge i_clk); while (!s_axis_tready);
        r = apply_request(func, key, val);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    initial begin
        bit [31:0] k;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        cycles = 0;
        idle_on = 1'b1;
        hold_cycles = 0;
        shadow_live = 0;
        shadow_limit = 10'd819;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_keys[i] = '0;
            shadow_vals[i] = '0;
        end
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFFFFFF;
        for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;

        // Directed requests: misses on an empty table, extreme keys and values,
        // replacement, and refusal once the live count reaches the limit.
        plan = '{
            '{0, 0, FUNC_FIND,   32'h0,        32'h0,        1, 0, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_FIND,   32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_INSERT, 32'h0,        32'hFFFFFFFF, 1, 0, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_INSERT, 32'hFFFFFFFF, 32'h0,        1, 0, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_FIND,   32'h0,        32'h0,        1, 1, 32'hFFFFFFFF, STATUS_DONE},
            '{0, 0, FUNC_FIND,   32'hFFFFFFFF, 32'h0,        1, 1, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_INSERT, 32'h0,        32'h12345678, 1, 1, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_FIND,   32'h0,        32'h0,        1, 1, 32'h12345678, STATUS_DONE},
            '{0, 0, FUNC_INSERT, 32'h1,        32'hAAAAAAAA, 0, 0, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_INSERT, 32'h2,        32'h55555555, 0, 0, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_FIND,   32'h1,        32'h0,        0, 0, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_FIND,   32'h2,        32'hFFFFFFFF, 0, 0, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_INSERT, 32'h80000000, 32'h1,        0, 0, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_FIND,   32'h80000000, 32'h0,        0, 0, 32'h0,        STATUS_DONE},
            '{1, 1, FUNC_FIND,   32'h0,        32'h0,        0, 0, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_INSERT, 32'h3,        32'h3,        1, 0, 32'h0,        STATUS_FULL},
            '{0, 0, FUNC_INSERT, 32'h1,        32'h7,        1, 1, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_FIND,   32'h3,        32'h0,        1, 0, 32'h0,        STATUS_DONE},
            '{1, 1023, FUNC_FIND, 32'h0,       32'h0,        0, 0, 32'h0,        STATUS_DONE},
            '{0, 0, FUNC_INSERT, 32'h3,        32'h3,        0, 0, 32'h0,        STATUS_DONE}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].cfg)
                write_fill_limit(plan[i].limit);
            else
                send_request(plan[i].func, plan[i].key, plan[i].val, plan[i].typed,
                             '{plan[i].ef, plan[i].ev, plan[i].es});
        end

        // Random requests, mostly on a pool of repeated keys so finds hit.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                write_fill_limit(10'd400);
            end
            idle_on = !(n >= 300 && n < 600);
            if (n == 200 || n == 1200) hold_cycles = 300;
            k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(POOL_N - 1)];
            send_request($urandom_range(1), k, $urandom, 1'b0, '{0, 0, 0});
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;

        drain_results();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
